/* design/pdlz_pkg.sv */
// ----------------------------------------------------------------------------
// pdlz_pkg: shared types and constants of the PalmDOC LZ77 decompressor
// Token codes, history geometry and the command word passed from the
// token decoder to the byte emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdlz_pkg;

  // Token byte boundaries.
  localparam logic [7:0] TOK_END      = 8'h00;
  localparam logic [7:0] TOK_LIT_MAX  = 8'h08;
  localparam logic [7:0] TOK_PASS_MAX = 8'h7F;
  localparam logic [7:0] TOK_REF_MAX  = 8'hBF;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  // History window.
  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = 11;

  // Bytes per command fit in four bits (at most ten).
  localparam int CMD_LEN_W  = 4;
  localparam logic [2:0] REF_LEN_BIAS = 3'd3;

  typedef enum logic [1:0] {
    PH_TOKEN   = 2'd0,
    PH_LITERAL = 2'd1,
    PH_BACKREF = 2'd2
  } phase_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  // One unit of work for the emitter: either up to two given bytes or a
  // copy out of the history. The byte count is already cut to the limits.
  typedef struct packed {
    logic                 is_copy;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [HIST_AW-1:0]   offset;
    logic [CMD_LEN_W-1:0] n;
    logic                 full;
  } cmd_t;

endpackage

`default_nettype wire

/* design/pdlz_ram.sv */
// ----------------------------------------------------------------------------
// pdlz_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdlz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/pdlz_front.sv */
// ----------------------------------------------------------------------------
// pdlz_front: token decoder
// Accepts compressed words, tracks the token phase and the output counts,
// and turns each word that yields output into one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdlz_front #(
  parameter int RECORD_SIZE = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_start,
  input  wire logic [31:0]   text_length,
  input  wire logic          push_ready,
  output logic               push_valid,
  output pdlz_pkg::cmd_t     push_cmd
);

  import pdlz_pkg::*;

  localparam int RC_W = $clog2(RECORD_SIZE + 1);
  localparam int CW   = (RC_W > CMD_LEN_W) ? RC_W : CMD_LEN_W;
  localparam logic [CW-1:0] REC_MAX = CW'(RECORD_SIZE);

  phase_t          phase_r, phase_nxt, phase_e;
  logic [3:0]      lit_r, lit_nxt, lit_e;
  logic [7:0]      pend_r, pend_nxt, pend_e;
  logic [CW-1:0]   rc_r, rc_nxt, rc_e;
  logic [31:0]     tc_r, tc_nxt;
  logic            stop_r, stop_nxt, stop_e;

  logic            accept;
  logic            blocked;
  logic [15:0]     ref_word;
  logic [CW-1:0]   room_r;
  logic [31:0]     room_t;
  logic [CMD_LEN_W-1:0] len, nr, n;
  logic            full;
  cmd_t            cmd;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // A record start clears the per-record state before the word is decoded.
  assign phase_e  = in_start ? PH_TOKEN : phase_r;
  assign lit_e    = in_start ? 4'd0 : lit_r;
  assign pend_e   = in_start ? 8'd0 : pend_r;
  assign rc_e     = in_start ? '0 : rc_r;
  assign stop_e   = in_start ? 1'b0 : stop_r;

  assign blocked  = stop_e || (tc_r >= text_length);
  assign ref_word = {pend_e, in_byte};
  assign room_r   = REC_MAX - rc_e;
  assign room_t   = text_length - tc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOKEN;
      lit_r   <= '0;
      pend_r  <= '0;
      rc_r    <= '0;
      tc_r    <= '0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      pend_r  <= pend_nxt;
      rc_r    <= rc_nxt;
      tc_r    <= tc_nxt;
      stop_r  <= stop_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    pend_nxt  = pend_r;
    rc_nxt    = rc_r;
    tc_nxt    = tc_r;
    stop_nxt  = stop_r;
    cmd       = '0;
    len       = '0;
    nr        = '0;
    n         = '0;
    full      = 1'b0;
    if (accept) begin
      phase_nxt = phase_e;
      lit_nxt   = lit_e;
      pend_nxt  = pend_e;
      rc_nxt    = rc_e;
      stop_nxt  = stop_e;
      if (!blocked) begin
        unique case (phase_e)
          PH_LITERAL: begin
            len     = CMD_LEN_W'(1);
            cmd.b0  = in_byte;
            lit_nxt = lit_e - 4'd1;
            if (lit_e == 4'd1) begin
              phase_nxt = PH_TOKEN;
            end
          end
          PH_BACKREF: begin
            len         = CMD_LEN_W'(ref_word[2:0]) + CMD_LEN_W'(REF_LEN_BIAS);
            cmd.is_copy = 1'b1;
            cmd.offset  = (ref_word[13:3] == '0) ? HIST_AW'(1) : ref_word[13:3];
            phase_nxt   = PH_TOKEN;
          end
          PH_TOKEN: begin
            priority if (in_byte == TOK_END) begin
              stop_nxt = 1'b1;
            end else if (in_byte <= TOK_LIT_MAX) begin
              lit_nxt   = in_byte[3:0];
              phase_nxt = PH_LITERAL;
            end else if (in_byte <= TOK_PASS_MAX) begin
              len    = CMD_LEN_W'(1);
              cmd.b0 = in_byte;
            end else if (in_byte <= TOK_REF_MAX) begin
              pend_nxt  = in_byte;
              phase_nxt = PH_BACKREF;
            end else begin
              len    = CMD_LEN_W'(2);
              cmd.b0 = SPACE_CHAR;
              cmd.b1 = {1'b0, in_byte[6:0]};
            end
          end
          default: begin
            phase_nxt = PH_TOKEN;
          end
        endcase

        // Cut the byte count at whichever limit comes first.
        if (len != '0) begin
          nr = (room_r < CW'(len)) ? room_r[CMD_LEN_W-1:0] : len;
          n  = (room_t < 32'(nr)) ? room_t[CMD_LEN_W-1:0] : nr;
          full     = (CW'(n) == room_r) || (32'(n) == room_t);
          cmd.n    = n;
          cmd.full = full;
          rc_nxt   = rc_e + CW'(n);
          tc_nxt   = tc_r + 32'(n);
          if (CW'(n) == room_r) begin
            stop_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign push_valid = accept && (cmd.n != '0);
  assign push_cmd   = cmd;

  a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= REC_MAX)
    else $error("record count passed the record size");

  a_full_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_cmd.full && (32'(push_cmd.n) != room_t)) |=> stop_r)
    else $error("record filled without ending the record");

endmodule

`default_nettype wire

/* design/pdlz_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pdlz_cmd_fifo: command queue between decoder and emitter
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdlz_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pdlz_pkg::cmd_t push_cmd,
  output logic               not_full,
  input  wire logic          pop,
  output logic               not_empty,
  output pdlz_pkg::cmd_t     head_cmd
);

  import pdlz_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  cmd_t          slots_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != NW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_SLOT) ? '0 : wr_r + AW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_SLOT) ? '0 : rd_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

/* design/pdlz_back.sv */
// ----------------------------------------------------------------------------
// pdlz_back: byte emitter
// Carries out each taken command one byte per cycle while the output is not
// stalled, keeps the history RAM and drives the registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdlz_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire pdlz_pkg::cmd_t cmd_in,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_full
);

  import pdlz_pkg::*;

  localparam logic [HIST_AW-1:0] WP_MAX = HIST_AW'(HIST_DEPTH - 1);

  back_state_t          state_r, state_nxt;
  cmd_t                 cur_r, cur_nxt;
  logic [CMD_LEN_W-1:0] k_r, k_nxt;
  logic [HIST_AW-1:0]   wp_r, wp_nxt;
  logic                 wrap_r, wrap_nxt;
  logic [HIST_AW-1:0]   src_r, src_nxt;
  logic                 rd_zero_r, rd_zero_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic                 ov_r, ov_nxt;
  logic [7:0]           ob_r, ob_nxt;
  logic                 ol_r, ol_nxt;
  logic                 of_r, of_nxt;

  logic                 can_emit;
  logic                 emit;
  logic                 is_last;
  logic [7:0]           byte_sel;
  logic                 ram_re;
  logic [HIST_AW-1:0]   ram_raddr;
  logic [7:0]           ram_rdata;

  pdlz_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .we      (emit),
    .waddr   (wp_r),
    .wdata   (byte_sel),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign can_emit = !ov_r || out_ready;
  assign is_last  = (k_r == cur_r.n - CMD_LEN_W'(1));

  // With distance one the source byte was written at the same edge that
  // the read sampled, so it comes from the previous output instead.
  always_comb begin
    if (cur_r.is_copy) begin
      if ((cur_r.offset == HIST_AW'(1)) && (k_r != '0)) begin
        byte_sel = prev_r;
      end else begin
        byte_sel = rd_zero_r ? 8'd0 : ram_rdata;
      end
    end else begin
      byte_sel = (k_r == '0) ? cur_r.b0 : cur_r.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      k_r     <= '0;
      wp_r    <= '0;
      wrap_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      wp_r    <= wp_nxt;
      wrap_r  <= wrap_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    src_r     <= src_nxt;
    rd_zero_r <= rd_zero_nxt;
    prev_r    <= prev_nxt;
    ob_r      <= ob_nxt;
    ol_r      <= ol_nxt;
    of_r      <= of_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    k_nxt       = k_r;
    wp_nxt      = wp_r;
    wrap_nxt    = wrap_r;
    src_nxt     = src_r;
    rd_zero_nxt = rd_zero_r;
    prev_nxt    = prev_r;
    ov_nxt      = ov_r && !out_ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    of_nxt      = of_r;
    cmd_pop     = 1'b0;
    emit        = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = src_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          cur_nxt     = cmd_in;
          k_nxt       = '0;
          src_nxt     = wp_r - cmd_in.offset;
          ram_re      = 1'b1;
          ram_raddr   = wp_r - cmd_in.offset;
          // Slots never written since reset read as zero.
          rd_zero_nxt = !(wrap_r || (cmd_in.offset <= wp_r));
          state_nxt   = BK_RUN;
        end
      end
      BK_RUN: begin
        if (can_emit) begin
          emit        = 1'b1;
          ov_nxt      = 1'b1;
          ob_nxt      = byte_sel;
          ol_nxt      = is_last;
          of_nxt      = is_last && cur_r.full;
          prev_nxt    = byte_sel;
          wp_nxt      = wp_r + HIST_AW'(1);
          wrap_nxt    = wrap_r || (wp_r == WP_MAX);
          k_nxt       = k_r + CMD_LEN_W'(1);
          src_nxt     = src_r + HIST_AW'(1);
          ram_re      = 1'b1;
          ram_raddr   = src_r + HIST_AW'(1);
          rd_zero_nxt = !(wrap_nxt || ((src_r + HIST_AW'(1)) < wp_nxt));
          if (is_last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_full  = of_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) |-> ((cur_r.n != '0) && (k_r < cur_r.n)))
    else $error("emitter ran past the end of its command");

  a_full_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full) |-> out_last)
    else $error("full flag on a byte that does not end its word");

endmodule

`default_nettype wire

/* design/palmdoc_lz77_decompressor.sv */
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor: streaming PalmDOC LZ77 decompressor
// Decodes one compressed byte per input word into zero to ten output bytes.
// ----------------------------------------------------------------------------
// The block takes one compressed byte per input word, with tuser marking the
// first byte of a record, and returns the decompressed bytes one per output
// word; tlast marks the final byte caused by one input word and tuser flags
// the byte that fills the record or reaches the configured text length.
// A decoder front end takes one input word per cycle while its four-entry
// command queue has room; it tracks the token phase and the record and total
// byte counts, so limits are applied there and words that produce nothing
// (run headers, the first back-reference byte, ignored bytes) never reach the
// back end. The emitter back end takes a command in its idle state, which
// also starts a read on the single, registered read port of the 2048-byte
// history RAM, and then emits the command's bytes in order while the output
// is not stalled; it takes the next command only after the last byte.
// The history needs no clearing pass after reset: the write pointer and a
// wrap flag mark which slots were written, and unwritten slots read as zero.
// text_length is written through the cfg channel, which is always ready;
// write it only while the block is idle. Its reset value, all ones, lets
// output run to at most 2^32 - 1 bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palmdoc_lz77_decompressor #(
  parameter int RECORD_SIZE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic [0:0]  in_tuser,   // [0] record_start

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  output logic [0:0]       out_tuser,  // [0] record_full

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  import pdlz_pkg::*;

  logic [31:0] text_length_r, text_length_nxt;
  logic        push_valid;
  cmd_t        push_cmd;
  logic        q_not_full;
  logic        q_not_empty;
  cmd_t        q_head;
  logic        q_pop;
  logic        out_full;

  // The register is always writable; the caller keeps writes to idle time.
  assign cfg_ready       = 1'b1;
  assign text_length_nxt = (cfg_valid && cfg_ready) ? cfg_data : text_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r <= 32'hFFFF_FFFF;
    end else begin
      text_length_r <= text_length_nxt;
    end
  end

  // Front end: token decode, limits and command generation.
  pdlz_front #(
    .RECORD_SIZE (RECORD_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .in_start    (in_tuser[0]),
    .text_length (text_length_r),
    .push_ready  (q_not_full),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd)
  );

  // Queue that decouples decode from byte emission.
  pdlz_cmd_fifo #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  // Back end: history RAM and output register.
  pdlz_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd_in    (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_full  (out_full)
  );

  assign out_tuser = out_full;

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == q_not_full)
    else $error("input ready does not follow queue space");

endmodule

`default_nettype wire
